// ===== hw/rtl/lgu_pkg.sv =====
`timescale 1ns / 1ps

package lgu_pkg;

  // Width of the operand, multiple and divisor fields on the ports
  localparam int unsigned FIELD_W = 32;

  // Default operand width, range 8 to 32
  localparam int unsigned OPERAND_WIDTH_DEF = 32;

  typedef struct packed {
    logic signed [FIELD_W-1:0] first_operand;
    logic signed [FIELD_W-1:0] second_operand;
  } lgu_in_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] multiple;
    logic        [FIELD_W-1:0] divisor;
    logic                      overflow;
  } lgu_out_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic gcd_step;
    logic gcd_latch;
    logic div_step;
    logic mul_init;
    logic mul_step;
    logic out_load;
  } lgu_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic gcd_done;
    logic b_zero;
  } lgu_status_t;

endpackage

// ===== hw/rtl/lgu_datapath.sv =====
`timescale 1ns / 1ps

module lgu_datapath import lgu_pkg::*; #(
  parameter int unsigned OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
  input  logic        clk_i,
  input  lgu_in_t     in_word_i,
  input  lgu_cmd_t    cmd_i,
  output lgu_status_t status_o,
  output lgu_out_t    out_word_o
);

  localparam int unsigned W     = OPERAND_WIDTH;
  localparam int unsigned CNT_W = $clog2(W);
  localparam logic [W-1:0] MULT_MAX = {1'b0, {(W-1){1'b1}}};

  logic [W-1:0]     a_q, ma_q, mb_q;
  logic [W-1:0]     x_q, y_q, g_q, rem_q, quo_q;
  logic [CNT_W-1:0] k_q;
  logic [2*W-1:0]   prod_q;
  lgu_out_t         out_q;

  logic [W-1:0] a_in, b_in, ma_in, mb_in;
  logic [W-1:0] g_base, rem_sh, quo_res;
  logic         rem_ge, ovf;
  logic [W:0]   mul_sum;
  logic signed [W-1:0] a_signed, mult_signed;

  // Only the low operand bits count, taken as two's complement
  assign a_in  = in_word_i.first_operand[W-1:0];
  assign b_in  = in_word_i.second_operand[W-1:0];
  assign ma_in = a_in[W-1] ? (~a_in + W'(1)) : a_in;
  assign mb_in = b_in[W-1] ? (~b_in + W'(1)) : b_in;

  assign status_o.gcd_done = (x_q == '0) || (y_q == '0);
  assign status_o.b_zero   = (mb_q == '0);

  // Restore the common power of two onto whichever value is left
  assign g_base = (x_q == '0) ? y_q : x_q;

  // One restoring division step; remainder stays below the divisor
  assign rem_sh = {rem_q[W-2:0], quo_q[W-1]};
  assign rem_ge = (rem_sh >= g_q);

  // One shift-and-add multiply step
  assign mul_sum = {1'b0, prod_q[2*W-1:W]} + (prod_q[0] ? {1'b0, mb_q} : {(W+1){1'b0}});

  assign ovf         = |prod_q[2*W-1:W-1];
  assign quo_res     = ovf ? MULT_MAX : prod_q[W-1:0];
  assign a_signed    = a_q;
  assign mult_signed = quo_res;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      a_q  <= a_in;
      ma_q <= ma_in;
      mb_q <= mb_in;
      x_q  <= ma_in;
      y_q  <= mb_in;
      k_q  <= '0;
    end
    if (cmd_i.gcd_step) begin
      if (!x_q[0] && !y_q[0]) begin
        x_q <= x_q >> 1;
        y_q <= y_q >> 1;
        k_q <= k_q + CNT_W'(1);
      end else if (!x_q[0]) begin
        x_q <= x_q >> 1;
      end else if (!y_q[0]) begin
        y_q <= y_q >> 1;
      end else if (x_q >= y_q) begin
        x_q <= x_q - y_q;
      end else begin
        y_q <= y_q - x_q;
      end
    end
    if (cmd_i.gcd_latch) begin
      g_q   <= g_base << k_q;
      quo_q <= ma_q;
      rem_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= rem_ge ? (rem_sh - g_q) : rem_sh;
      quo_q <= {quo_q[W-2:0], rem_ge};
    end
    if (cmd_i.mul_init) begin
      prod_q <= {{W{1'b0}}, quo_q};
    end
    if (cmd_i.mul_step) begin
      prod_q <= {mul_sum, prod_q[W-1:1]};
    end
    if (cmd_i.out_load) begin
      out_q.divisor <= FIELD_W'(g_q);
      if (status_o.b_zero) begin
        out_q.multiple <= FIELD_W'(a_signed);
        out_q.overflow <= 1'b0;
      end else begin
        out_q.multiple <= FIELD_W'(mult_signed);
        out_q.overflow <= ovf;
      end
    end
  end

  assign out_word_o = out_q;

endmodule

// ===== hw/rtl/lgu_controller.sv =====
`timescale 1ns / 1ps

module lgu_controller import lgu_pkg::*; #(
  parameter int unsigned OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  input  lgu_status_t status_i,
  output lgu_cmd_t    cmd_o
);

  localparam int unsigned CNT_W = $clog2(OPERAND_WIDTH);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(OPERAND_WIDTH - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD,
    ST_DIV,
    ST_MINIT,
    ST_MUL,
    ST_FIN
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;
  logic             out_valid_q;
  logic             out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.gcd_step  = (state_q == ST_GCD) && !status_i.gcd_done;
    cmd_o.gcd_latch = (state_q == ST_GCD) && status_i.gcd_done;
    cmd_o.div_step  = (state_q == ST_DIV);
    cmd_o.mul_init  = (state_q == ST_MINIT);
    cmd_o.mul_step  = (state_q == ST_MUL);
    cmd_o.out_load  = (state_q == ST_FIN) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // Drop the result word once taken; a new load takes priority
      if ((state_q == ST_FIN) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_GCD;
          end
        end
        ST_GCD: begin
          cnt_q <= '0;
          if (status_i.gcd_done) begin
            state_q <= status_i.b_zero ? ST_FIN : ST_DIV;
          end
        end
        ST_DIV: begin
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == LAST_STEP) begin
            state_q <= ST_MINIT;
          end
        end
        ST_MINIT: begin
          cnt_q   <= '0;
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == LAST_STEP) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/integer_lcm_gcd_unit.sv =====
`timescale 1ns / 1ps

// Greatest common divisor and least common multiple of two signed integers.
// Input channel: in_valid_i / in_stall_o carry one word with first_operand
// and second_operand; only the low OPERAND_WIDTH bits count, as two's
// complement. Output channel: out_valid_o / out_stall_i carry one word with
// multiple, divisor and overflow for every input word, in order.
// A word is taken whenever in_stall_o is low; the unit then works on it alone.
// Sequence: a load, then binary GCD at one subtract or shift a cycle, and a
// latch of the result; each subtract is followed by a halving. Then restoring
// divide steps for magnitude(a)/gcd, a set-up step, shift-add multiply steps
// by magnitude(b), and a load of the output register; the unit then returns
// to idle to take the next word. With a zero second operand the divide and
// multiply are skipped (the first operand passes through). The output
// register lets the next word be taken while a result still waits; a stalled
// receiver holds the unit in its final state once the following result is
// ready. Reset clears the controller and the output valid; the datapath
// registers hold no state worth clearing.
module integer_lcm_gcd_unit import lgu_pkg::*; #(
  parameter int unsigned OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  lgu_in_t  in_word_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output lgu_out_t out_word_o
);

  lgu_cmd_t    cmd;
  lgu_status_t status;

  // Sequence the load, GCD, divide, multiply and hand-off phases
  lgu_controller #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Magnitudes, GCD registers, divider, multiplier and output register
  lgu_datapath #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .in_word_i  (in_word_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_word_o (out_word_o)
  );

endmodule
